[design/jdd_pkg.sv]
// Shared types, constants and the month offset table of the Julian day date arithmetic core.
package jdd_pkg;

	// Width of a day number (JD + 0.5) for years 0..16383
	localparam int DN_W = 23;

	// Width of the day count and of the difference result
	localparam int CNT_W = 22;

	// First day number of the Gregorian calendar
	localparam logic [DN_W-1:0] JULIAN_LIMIT = 23'd2299161;

	// Largest day difference that can be reported
	localparam logic [CNT_W-1:0] DIFF_MAX = 22'h3FFFFF;

	// Exact floor division by reciprocal: x/d == (x * ceil(2^k/d)) >> k over the input range.
	// y/100 for y < 2^14
	localparam int DIV100_SHIFT = 21;
	localparam logic [14:0] DIV100_MULT =
		15'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);

	// (4z - 7468865)/146097 for x < 2^25
	localparam int GREG_SHIFT = 43;
	localparam logic [25:0] GREG_MULT =
		26'(((64'd1 << GREG_SHIFT) + 64'd146096) / 64'd146097);

	// (20b - 2442)/7305 for x < 2^28
	localparam int CENT_SHIFT = 41;
	localparam logic [28:0] CENT_MULT =
		29'(((64'd1 << CENT_SHIFT) + 64'd7304) / 64'd7305);

	// (10000*bd)/306001 for 10000*bd < 2^23; the factor 10000 is folded into the constant
	localparam int MON_SHIFT = 42;
	localparam logic [37:0] MON_MULT =
		38'(64'd10000 * (((64'd1 << MON_SHIFT) + 64'd306000) / 64'd306001));

	// Transaction sideband that travels alongside the inverse pipeline
	typedef struct packed {
		logic             action;
		logic             underflow;
		logic [CNT_W-1:0] diff;
	} jdd_tag_t;

	// floor(30.6001 * k) for k = 0..16
	function automatic logic [8:0] month_offset(input logic [4:0] k);
		logic [8:0] r;
		case (k)
			5'd0:    r = 9'd0;
			5'd1:    r = 9'd30;
			5'd2:    r = 9'd61;
			5'd3:    r = 9'd91;
			5'd4:    r = 9'd122;
			5'd5:    r = 9'd153;
			5'd6:    r = 9'd183;
			5'd7:    r = 9'd214;
			5'd8:    r = 9'd244;
			5'd9:    r = 9'd275;
			5'd10:   r = 9'd306;
			5'd11:   r = 9'd336;
			5'd12:   r = 9'd367;
			5'd13:   r = 9'd397;
			5'd14:   r = 9'd428;
			5'd15:   r = 9'd459;
			5'd16:   r = 9'd489;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

[design/julian_day_date_arithmetic_core.sv]
// Top level of the Julian day date arithmetic core: forward conversion and difference stages.
//
// One transaction enters per clock: start is taken whenever it is high, since busy is held
// low, and the result appears on the result ports for exactly one cycle, marked by done.
// The receiver cannot stall the core, so capture the result in the cycle done is high.
// The stages follow the chain of constant multiplications: two stages convert both dates
// to day numbers, one stage forms the difference or the shifted day number, and seven
// stages invert the day number back to a date, with a register after
// every reciprocal multiply. Action 0 gives the absolute day difference (saturating) with
// the date fields zero; action 1 gives the date day_count days before the first date with
// day_difference zero, or raises underflow with the date fields zero when that date falls
// before day number 0. result_year is two's complement and wraps within its 15 bits.
module julian_day_date_arithmetic_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       action,
	input  logic [4:0]                 first_day,
	input  logic [3:0]                 first_month,
	input  logic [13:0]                first_year,
	input  logic [4:0]                 second_day,
	input  logic [3:0]                 second_month,
	input  logic [13:0]                second_year,
	input  logic [21:0]                day_count,
	output logic                       done,
	output logic [21:0]                day_difference,
	output logic [4:0]                 result_day,
	output logic [3:0]                 result_month,
	output logic signed [14:0]         result_year,
	output logic                       underflow
);

	logic                              valid_s1;
	logic                              valid_s2;
	logic                              valid_s3;
	logic                              action_s1;
	logic                              action_s2;
	logic [jdd_pkg::CNT_W-1:0]         count_s1;
	logic [jdd_pkg::CNT_W-1:0]         count_s2;

	logic [jdd_pkg::DN_W-1:0]          n1;
	logic [jdd_pkg::DN_W-1:0]          n2;

	logic [23:0]                       delta;
	logic [23:0]                       delta_abs;
	logic [23:0]                       z_full;
	jdd_pkg::jdd_tag_t                 tag;
	jdd_pkg::jdd_tag_t                 tag_s3;
	logic [jdd_pkg::DN_W-1:0]          z_s3;

	// The pipeline never stalls, so accept a transaction every cycle
	assign busy = 1'b0;

	// Advance valid bits with each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Hold the action and day count alongside the day number stages
	always_ff @(posedge clk) begin
		action_s1 <= action;
		count_s1  <= day_count;
		action_s2 <= action_s1;
		count_s2  <= count_s1;
	end

	jdd_day_number u_first (
		.clk        (clk),
		.day        (first_day),
		.month      (first_month),
		.year       (first_year),
		.day_number (n1)
	);

	jdd_day_number u_second (
		.clk        (clk),
		.day        (second_day),
		.month      (second_month),
		.year       (second_year),
		.day_number (n2)
	);

	// Stage 3: difference with saturation for action 0, shifted day number for action 1
	always_comb begin
		delta     = {1'b0, n1} - {1'b0, n2};
		delta_abs = delta[23] ? (24'd0 - delta) : delta;
		z_full    = {1'b0, n1} - {2'b00, count_s2};

		tag.action    = action_s2;
		tag.underflow = action_s2 && z_full[23];
		if (action_s2) begin
			tag.diff = '0;
		end else if (delta_abs > 24'(jdd_pkg::DIFF_MAX)) begin
			tag.diff = jdd_pkg::DIFF_MAX;
		end else begin
			tag.diff = delta_abs[jdd_pkg::CNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		tag_s3 <= tag;
		z_s3   <= z_full[jdd_pkg::DN_W-1:0];
	end

	jdd_from_day u_from_day (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (valid_s3),
		.in_tag         (tag_s3),
		.in_z           (z_s3),
		.done           (done),
		.day_difference (day_difference),
		.result_day     (result_day),
		.result_month   (result_month),
		.result_year    (result_year),
		.underflow      (underflow)
	);

endmodule

[design/jdd_day_number.sv]
// Two-stage pipeline that maps a calendar date to its day number.
module jdd_day_number (
	input  logic                      clk,
	input  logic [4:0]                day,
	input  logic [3:0]                month,
	input  logic [13:0]               year,
	output logic [jdd_pkg::DN_W-1:0]  day_number
);

	logic                     is_jf;
	logic [13:0]              y_for_a;
	logic [14:0]              y_shift;
	logic [4:0]               m_adj;
	logic [28:0]              a_prod;
	logic [25:0]              y_prod;

	logic [28:0]              a_prod_s1;
	logic [22:0]              yterm_s1;
	logic [8:0]               moff_s1;
	logic [4:0]               day_s1;

	logic [7:0]               a_cent;
	logic [23:0]              sum;
	logic [jdd_pkg::DN_W-1:0] dn_s2;

	// January and February count as months 13 and 14 of the previous year
	always_comb begin
		is_jf   = (month == 4'd1) || (month == 4'd2);
		// year 0 in Jan/Feb gives year -1, whose century truncates to zero
		y_for_a = (is_jf && (year == 14'd0)) ? 14'd0 : (year - 14'(is_jf));
		y_shift = 15'(year) + 15'd4716 - 15'(is_jf);
		m_adj   = 5'(month) + (is_jf ? 5'd12 : 5'd0);
		a_prod  = 29'(y_for_a) * 29'(jdd_pkg::DIV100_MULT);
		y_prod  = 26'(y_shift) * 26'd1461;
	end

	always_ff @(posedge clk) begin
		a_prod_s1 <= a_prod;
		yterm_s1  <= y_prod[24:2];
		moff_s1   <= jdd_pkg::month_offset(m_adj + 5'd1);
		day_s1    <= day;
	end

	// N = yterm + moff + D + 2 - A + A/4 - 1524
	always_comb begin
		a_cent = a_prod_s1[jdd_pkg::DIV100_SHIFT +: 8];
		sum    = 24'(yterm_s1) + 24'(moff_s1) + 24'(day_s1) + 24'(a_cent >> 2)
			- 24'(a_cent) - 24'd1522;
	end

	always_ff @(posedge clk) begin
		dn_s2 <= sum[jdd_pkg::DN_W-1:0];
	end

	assign day_number = dn_s2;

endmodule

[design/jdd_from_day.sv]
// Seven-stage pipeline that turns a day number back into a date and forms the final result.
module jdd_from_day (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  jdd_pkg::jdd_tag_t          in_tag,
	input  logic [jdd_pkg::DN_W-1:0]   in_z,
	output logic                       done,
	output logic [jdd_pkg::CNT_W-1:0]  day_difference,
	output logic [4:0]                 result_day,
	output logic [3:0]                 result_month,
	output logic signed [14:0]         result_year,
	output logic                       underflow
);

	// Stage 4: Gregorian correction product
	logic [24:0]              xg;
	logic                     valid_s4;
	jdd_pkg::jdd_tag_t        tag_s4;
	logic [22:0]              z_s4;
	logic                     greg_s4;
	logic [50:0]              prodg_s4;

	// Stage 5: b = A + 1524
	logic [7:0]               alpha;
	logic [23:0]              a_sum;
	logic                     valid_s5;
	jdd_pkg::jdd_tag_t        tag_s5;
	logic [22:0]              b_s5;

	// Stage 6: 20b - 2442
	logic                     valid_s6;
	jdd_pkg::jdd_tag_t        tag_s6;
	logic [22:0]              b_s6;
	logic [27:0]              xc_s6;

	// Stage 7: year count product
	logic                     valid_s7;
	jdd_pkg::jdd_tag_t        tag_s7;
	logic [22:0]              b_s7;
	logic [56:0]              prodc_s7;

	// Stage 8: C and B - D
	logic [14:0]              c_val;
	logic [24:0]              d_prod;
	logic [22:0]              bd_full;
	logic                     valid_s8;
	jdd_pkg::jdd_tag_t        tag_s8;
	logic [14:0]              c_s8;
	logic [8:0]               bd_s8;

	// Stage 9: month product
	logic                     valid_s9;
	jdd_pkg::jdd_tag_t        tag_s9;
	logic [14:0]              c_s9;
	logic [8:0]               bd_s9;
	logic [46:0]              prode_s9;

	// Stage 10: date fields
	logic [4:0]               e_val;
	logic [8:0]               day_full;
	logic [3:0]               month_val;
	logic [14:0]              year_val;
	logic                     keep;
	logic                     valid_s10;
	jdd_pkg::jdd_tag_t        tag_s10;
	logic [4:0]               day_s10;
	logic [3:0]               month_s10;
	logic [14:0]              year_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
		end else begin
			valid_s4  <= in_valid;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
		end
	end

	// Only meaningful on the Gregorian side, where 4z exceeds the offset
	assign xg = {in_z, 2'b00} - 25'd7468865;

	always_ff @(posedge clk) begin
		tag_s4   <= in_tag;
		z_s4     <= in_z;
		greg_s4  <= (in_z >= jdd_pkg::JULIAN_LIMIT);
		prodg_s4 <= 51'(xg) * 51'(jdd_pkg::GREG_MULT);
	end

	always_comb begin
		alpha = prodg_s4[jdd_pkg::GREG_SHIFT +: 8];
		a_sum = greg_s4 ? (24'(z_s4) + 24'd1 + 24'(alpha) - 24'(alpha >> 2)) : 24'(z_s4);
	end

	always_ff @(posedge clk) begin
		tag_s5 <= tag_s4;
		b_s5   <= 23'(a_sum + 24'd1524);
	end

	always_ff @(posedge clk) begin
		tag_s6 <= tag_s5;
		b_s6   <= b_s5;
		xc_s6  <= 28'(b_s5) * 28'd20 - 28'd2442;
	end

	always_ff @(posedge clk) begin
		tag_s7   <= tag_s6;
		b_s7     <= b_s6;
		prodc_s7 <= 57'(xc_s6) * 57'(jdd_pkg::CENT_MULT);
	end

	always_comb begin
		c_val   = prodc_s7[jdd_pkg::CENT_SHIFT +: 15];
		d_prod  = 25'(c_val) * 25'd1461;
		bd_full = b_s7 - d_prod[24:2];
	end

	always_ff @(posedge clk) begin
		tag_s8 <= tag_s7;
		c_s8   <= c_val;
		bd_s8  <= bd_full[8:0];
	end

	always_ff @(posedge clk) begin
		tag_s9   <= tag_s8;
		c_s9     <= c_s8;
		bd_s9    <= bd_s8;
		prode_s9 <= 47'(bd_s8) * 47'(jdd_pkg::MON_MULT);
	end

	// Month from E; year from C, one higher for January and February
	always_comb begin
		e_val    = prode_s9[jdd_pkg::MON_SHIFT +: 5];
		day_full = bd_s9 - jdd_pkg::month_offset(e_val);
		month_val = 4'd0;
		if ((e_val >= 5'd4) && (e_val < 5'd14)) begin
			month_val = 4'(e_val - 5'd1);
		end else if ((e_val == 5'd14) || (e_val == 5'd15)) begin
			month_val = 4'(e_val - 5'd13);
		end
		year_val = 15'd0;
		if (month_val > 4'd2) begin
			year_val = c_s9 - 15'd4716;
		end else if ((month_val == 4'd1) || (month_val == 4'd2)) begin
			year_val = c_s9 - 15'd4715;
		end
		keep = tag_s9.action && !tag_s9.underflow;
	end

	always_ff @(posedge clk) begin
		tag_s10   <= tag_s9;
		day_s10   <= keep ? day_full[4:0] : 5'd0;
		month_s10 <= keep ? month_val : 4'd0;
		year_s10  <= keep ? year_val : 15'd0;
	end

	assign done           = valid_s10;
	assign day_difference = tag_s10.diff;
	assign result_day     = day_s10;
	assign result_month   = month_s10;
	assign result_year    = year_s10;
	assign underflow      = tag_s10.underflow;

endmodule

[sim/tb_julian_day_date_arithmetic_core.sv]
// Self-checking testbench for the Julian day date arithmetic core.
module tb_julian_day_date_arithmetic_core;

	// Action codes carried by the action input
	localparam logic ACT_DIFF  = 1'b0;  // absolute day difference of two dates
	localparam logic ACT_SHIFT = 1'b1;  // first date moved back by day_count

	localparam int  RANDOM_ITEMS = 650;
	localparam int  CYCLE_LIMIT  = 200000;
	localparam int  SETTLE_CYCLES = 20;   // extra idle time at the end to catch stray results
	localparam int  MAX_REPORTS  = 10;
	localparam longint GREG_FIRST = 2299161;
	localparam longint COUNT_MAX  = 4194303;

	// One transaction as driven on the input ports
	typedef struct packed {
		logic                     act;
		logic [4:0]               d1;
		logic [3:0]               m1;
		logic [13:0]              y1;
		logic [4:0]               d2;
		logic [3:0]               m2;
		logic [13:0]              y2;
		logic [jdd_pkg::CNT_W-1:0] cnt;
	} date_job_t;

	// One result as seen on the result ports
	typedef struct packed {
		logic [jdd_pkg::CNT_W-1:0] diff;
		logic [4:0]                day;
		logic [3:0]                month;
		logic [14:0]               year;
		logic                      uflow;
	} date_result_t;

	// Directed row: the expected result is typed in only where known is set
	typedef struct packed {
		logic         known;
		date_job_t    job;
		date_result_t res;
	} date_row_t;

	// Result still owed by the core, with the transaction that caused it
	typedef struct packed {
		date_job_t    job;
		date_result_t res;
	} owed_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic                      action;
	logic [4:0]                first_day;
	logic [3:0]                first_month;
	logic [13:0]               first_year;
	logic [4:0]                second_day;
	logic [3:0]                second_month;
	logic [13:0]               second_year;
	logic [21:0]               day_count;
	logic                      done;
	logic [21:0]               day_difference;
	logic [4:0]                result_day;
	logic [3:0]                result_month;
	logic signed [14:0]        result_year;
	logic                      underflow;

	owed_result_t  owed_q[$];
	date_row_t     directed_rows[$];
	date_result_t  typed_res;
	logic          typed_valid;
	int            accepted_n;
	int            mismatch_n;
	int            cycle_n;
	int            diff_n;
	int            sat_n;
	int            shift_n;
	int            uflow_n;

	julian_day_date_arithmetic_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.first_day      (first_day),
		.first_month    (first_month),
		.first_year     (first_year),
		.second_day     (second_day),
		.second_month   (second_month),
		.second_year    (second_year),
		.day_count      (day_count),
		.done           (done),
		.day_difference (day_difference),
		.result_day     (result_day),
		.result_month   (result_month),
		.result_year    (result_year),
		.underflow      (underflow)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Date predictor
	// ------------------------------------------------------------------

	// Day number (JD + 0.5) of a date, Gregorian correction always applied.
	// January and February count as months 13 and 14 of the year before;
	// any other month value, legal or not, goes into the formula unchanged.
	function automatic longint day_serial(input logic [4:0] d, input logic [3:0] m,
			input logic [13:0] y);
		longint yy, mm, dd, cent, corr;
		yy = y;
		mm = m;
		dd = d;
		if (mm == 1 || mm == 2) begin
			yy = yy - 1;
			mm = mm + 12;
		end
		cent = yy / 100;
		corr = 2 - cent + cent / 4;
		return (1461 * (yy + 4716)) / 4 + (306001 * (mm + 1)) / 10000 + dd + corr - 1524;
	endfunction

	// Expected result of one transaction. All quotients truncate toward zero,
	// which is what signed division on longint does as well.
	function automatic date_result_t predict_date(input date_job_t j);
		date_result_t r;
		longint n1, n2, span, z, alpha, a, b, c, d, e, dd, mm, yy, cnt_l;
		r = '0;
		n1 = day_serial(j.d1, j.m1, j.y1);
		if (j.act == ACT_DIFF) begin
			n2 = day_serial(j.d2, j.m2, j.y2);
			span = n1 - n2;
			if (span < 0)
				span = -span;
			// saturate: only years outside the legal range get this far apart
			if (span > longint'(jdd_pkg::DIFF_MAX))
				span = longint'(jdd_pkg::DIFF_MAX);
			r.diff = span[21:0];
		end else begin
			cnt_l = j.cnt;
			z = n1 - cnt_l;
			if (z < 0) begin
				// before day zero: flag it and leave the date fields at zero
				r.uflow = 1'b1;
			end else begin
				// Julian rule below the first Gregorian day, Gregorian above it
				if (z < GREG_FIRST) begin
					a = z;
				end else begin
					alpha = (4 * z - 7468865) / 146097;
					a = z + 1 + alpha - alpha / 4;
				end
				b = a + 1524;
				c = (20 * b - 2442) / 7305;
				d = (1461 * c) / 4;
				e = (10000 * (b - d)) / 306001;
				dd = b - d - (306001 * e) / 10000;
				mm = 0;
				yy = 0;
				// an out-of-range E leaves month and year at zero
				if (e < 14 && e >= 4)
					mm = e - 1;
				if (e == 14 || e == 15)
					mm = e - 13;
				if (mm > 2)
					yy = c - 4716;
				else if (mm == 1 || mm == 2)
					yy = c - 4715;
				r.day   = dd[4:0];
				r.month = mm[3:0];
				r.year  = yy[14:0];
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic date_job_t make_job(input logic act, input int d1, input int m1,
			input int y1, input int d2, input int m2, input int y2, input int cnt);
		date_job_t j;
		j.act = act;
		j.d1  = d1[4:0];
		j.m1  = m1[3:0];
		j.y1  = y1[13:0];
		j.d2  = d2[4:0];
		j.m2  = m2[3:0];
		j.y2  = y2[13:0];
		j.cnt = cnt[21:0];
		return j;
	endfunction

	function automatic date_result_t make_res(input int diff, input int day, input int month,
			input int year, input logic uflow);
		date_result_t r;
		r.diff  = diff[21:0];
		r.day   = day[4:0];
		r.month = month[3:0];
		r.year  = year[14:0];
		r.uflow = uflow;
		return r;
	endfunction

	function automatic void add_row(input logic known, input date_job_t j,
			input date_result_t r);
		date_row_t row;
		row.known = known;
		row.job   = j;
		row.res   = r;
		directed_rows.push_back(row);
	endfunction

	// Year spread: early years, around the calendar switch, late years, anywhere
	function automatic logic [13:0] pick_year();
		case ($urandom_range(0, 5))
			0:       return 14'($urandom_range(1, 100));
			1:       return 14'($urandom_range(1500, 1700));
			2:       return 14'($urandom_range(9900, 9999));
			default: return 14'($urandom_range(1, 9999));
		endcase
	endfunction

	// Random transaction. Most carry legal dates; a tenth use the full width of
	// every field. The day count is steered toward day zero and the calendar
	// switch often enough to hit both edges from either side.
	function automatic date_job_t random_job();
		date_job_t j;
		longint    n1, cnt_l;
		int        k;
		j.act = 1'($urandom_range(0, 1));
		j.cnt = 22'($urandom_range(0, 22'h3FFFFF));
		if ($urandom_range(0, 9) == 0) begin
			j.d1 = 5'($urandom_range(0, 31));
			j.m1 = 4'($urandom_range(0, 15));
			j.y1 = 14'($urandom_range(0, 16383));
			j.d2 = 5'($urandom_range(0, 31));
			j.m2 = 4'($urandom_range(0, 15));
			j.y2 = 14'($urandom_range(0, 16383));
			return j;
		end
		j.d1 = 5'($urandom_range(1, 31));
		j.m1 = 4'($urandom_range(1, 12));
		j.y1 = pick_year();
		j.d2 = 5'($urandom_range(1, 31));
		j.m2 = 4'($urandom_range(1, 12));
		j.y2 = pick_year();
		n1 = day_serial(j.d1, j.m1, j.y1);
		k = $urandom_range(0, 4);
		case ($urandom_range(0, 5))
			0, 1:    cnt_l = $urandom_range(0, 22'h3FFFFF);
			2:       cnt_l = $urandom_range(0, 3000);
			3:       cnt_l = n1 + k - 2;
			4:       cnt_l = n1 - GREG_FIRST + k - 2;
			default: cnt_l = $urandom_range(0, 800000);
		endcase
		if (cnt_l < 0)
			cnt_l = 0;
		if (cnt_l > COUNT_MAX)
			cnt_l = COUNT_MAX;
		j.cnt = cnt_l[21:0];
		return j;
	endfunction

	// Present one transaction and hold it until the core has taken it.
	// Call at a falling edge; returns at the falling edge after acceptance.
	task automatic issue(input date_job_t j, input logic known, input date_result_t r);
		int target;
		target       = accepted_n + 1;
		typed_valid  = known;
		typed_res    = r;
		start        <= 1'b1;
		action       <= j.act;
		first_day    <= j.d1;
		first_month  <= j.m1;
		first_year   <= j.y1;
		second_day   <= j.d2;
		second_month <= j.m2;
		second_year  <= j.y2;
		day_count    <= j.cnt;
		do @(negedge clk); while (accepted_n < target);
	endtask

	// Drop start for a number of cycles and scramble the payload meanwhile
	task automatic idle(input int cycles);
		repeat (cycles) begin
			start        <= 1'b0;
			action       <= 1'($urandom_range(0, 1));
			first_day    <= 5'($urandom_range(0, 31));
			first_month  <= 4'($urandom_range(0, 15));
			first_year   <= 14'($urandom_range(0, 16383));
			second_day   <= 5'($urandom_range(0, 31));
			second_month <= 4'($urandom_range(0, 15));
			second_year  <= 14'($urandom_range(0, 16383));
			day_count    <= 22'($urandom_range(0, 22'h3FFFFF));
			@(negedge clk);
		end
	endtask

	task automatic drain();
		while (owed_q.size() != 0)
			idle(1);
	endtask

	// ------------------------------------------------------------------
	// Monitor: record accepted transactions, check every result
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		owed_result_t entry, want;
		date_result_t got;
		if (arst_n) begin
			// a transaction is taken at this edge: queue its expected result
			if (start && !busy) begin
				entry.job = '{act: action, d1: first_day, m1: first_month, y1: first_year,
					d2: second_day, m2: second_month, y2: second_year, cnt: day_count};
				entry.res = typed_valid ? typed_res : predict_date(entry.job);
				owed_q.push_back(entry);
				accepted_n++;
			end
			if (done) begin
				got = '{diff: day_difference, day: result_day, month: result_month,
					year: result_year, uflow: underflow};
				if (owed_q.size() == 0) begin
					mismatch_n++;
					if (mismatch_n <= MAX_REPORTS)
						$display("cycle %0d: result with no transaction outstanding", cycle_n);
				end else begin
					want = owed_q.pop_front();
					if (want.job.act == ACT_DIFF) begin
						diff_n++;
						if (want.res.diff == jdd_pkg::DIFF_MAX)
							sat_n++;
					end else begin
						shift_n++;
						if (want.res.uflow)
							uflow_n++;
					end
					if (got.diff !== want.res.diff || got.day !== want.res.day
							|| got.month !== want.res.month || got.year !== want.res.year
							|| got.uflow !== want.res.uflow) begin
						mismatch_n++;
						if (mismatch_n <= MAX_REPORTS) begin
							$display("cycle %0d: mismatch, action %0d first %0d/%0d/%0d second %0d/%0d/%0d count %0d",
								cycle_n, want.job.act, want.job.d1, want.job.m1, want.job.y1,
								want.job.d2, want.job.m2, want.job.y2, want.job.cnt);
							$display("  expected diff %0d date %0d/%0d/%0d underflow %0d",
								want.res.diff, want.res.day, want.res.month,
								$signed(want.res.year), want.res.uflow);
							$display("  actual   diff %0d date %0d/%0d/%0d underflow %0d",
								got.diff, got.day, got.month, $signed(got.year), got.uflow);
						end
					end
				end
			end
		end
	end

	// Watchdog: a hung handshake or a lost result ends the run here
	always @(posedge clk) begin
		cycle_n++;
		if (cycle_n == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_n,
				owed_q.size());
			$display("tb_julian_day_date_arithmetic_core: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int  sent, burst, i;
		bit  drained;
		accepted_n   = 0;
		mismatch_n   = 0;
		cycle_n      = 0;
		diff_n       = 0;
		sat_n        = 0;
		shift_n      = 0;
		uflow_n      = 0;
		typed_valid  = 1'b0;
		typed_res    = '0;
		arst_n       = 1'b0;
		start        = 1'b0;
		action       = ACT_DIFF;
		first_day    = '0;
		first_month  = '0;
		first_year   = '0;
		second_day   = '0;
		second_month = '0;
		second_year  = '0;
		day_count    = '0;

		// Directed rows: typed results for the obvious cases, predictor for the rest
		add_row(1, make_job(ACT_DIFF, 1, 1, 2000, 1, 1, 2000, 0), make_res(0, 0, 0, 0, 0));
		add_row(1, make_job(ACT_DIFF, 1, 1, 2000, 2, 1, 2000, 0), make_res(1, 0, 0, 0, 0));
		// leap day lies between these two
		add_row(1, make_job(ACT_DIFF, 1, 3, 2000, 28, 2, 2000, 0), make_res(2, 0, 0, 0, 0));
		// widest span the fields allow: saturates
		add_row(1, make_job(ACT_DIFF, 31, 12, 16383, 1, 1, 0, 0),
			make_res(4194303, 0, 0, 0, 0));
		add_row(1, make_job(ACT_SHIFT, 31, 12, 9999, 0, 0, 0, 0),
			make_res(0, 31, 12, 9999, 0));
		add_row(1, make_job(ACT_SHIFT, 15, 6, 2024, 31, 15, 16383, 0),
			make_res(0, 15, 6, 2024, 0));
		// far below day zero, and one day below it
		add_row(1, make_job(ACT_SHIFT, 1, 1, 1, 0, 0, 0, 4194303), make_res(0, 0, 0, 0, 1));
		add_row(1, make_job(ACT_SHIFT, 1, 1, 1, 0, 0, 0, 1721427), make_res(0, 0, 0, 0, 1));
		// exactly day zero
		add_row(0, make_job(ACT_SHIFT, 1, 1, 1, 0, 0, 0, 1721426), '0);
		// first Gregorian day and the Julian day before it
		add_row(0, make_job(ACT_SHIFT, 15, 10, 1582, 0, 0, 0, 0), '0);
		add_row(0, make_job(ACT_SHIFT, 15, 10, 1582, 0, 0, 0, 1), '0);
		add_row(0, make_job(ACT_DIFF, 15, 10, 1582, 4, 10, 1582, 0), '0);
		// month values outside 1..12 go through the formula as they are
		add_row(0, make_job(ACT_DIFF, 10, 0, 2000, 10, 1, 2000, 0), '0);
		add_row(0, make_job(ACT_SHIFT, 5, 13, 2000, 0, 0, 0, 0), '0);
		add_row(0, make_job(ACT_SHIFT, 31, 15, 16383, 0, 0, 0, 0), '0);
		add_row(0, make_job(ACT_DIFF, 0, 3, 2000, 1, 3, 2000, 0), '0);
		// year zero in January and February borrows year -1
		add_row(0, make_job(ACT_SHIFT, 1, 1, 0, 0, 0, 0, 0), '0);
		add_row(0, make_job(ACT_DIFF, 29, 2, 0, 1, 3, 0, 0), '0);
		// largest count: from year 9999 it lands deep in the Julian range, negative years
		add_row(0, make_job(ACT_SHIFT, 1, 1, 9999, 0, 0, 0, 4194303), '0);
		add_row(0, make_job(ACT_SHIFT, 31, 15, 16383, 31, 15, 16383, 4194303), '0);
		add_row(0, make_job(ACT_DIFF, 1, 1, 1, 31, 12, 9999, 4194303), '0);
		add_row(0, make_job(ACT_SHIFT, 29, 2, 2000, 31, 15, 16383, 365), '0);
		add_row(0, make_job(ACT_DIFF, 31, 12, 1, 1, 1, 2, 4194303), '0);

		// Hold reset, then release it between edges
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		idle(2);

		// Walk the directed rows back to back, then let the pipeline run empty
		for (i = 0; i < directed_rows.size(); i++)
			issue(directed_rows[i].job, directed_rows[i].known, directed_rows[i].res);
		drain();

		// Random part: bursts of random length, gaps of random length, and
		// a full drain halfway through so the pipeline runs empty once
		sent    = 0;
		drained = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && sent < RANDOM_ITEMS) begin
				issue(random_job(), 1'b0, '0);
				sent++;
				burst--;
			end
			if (!drained && sent >= RANDOM_ITEMS / 2) begin
				drain();
				drained = 1;
			end
			case ($urandom_range(0, 3))
				0:       ;
				1, 2:    idle($urandom_range(1, 4));
				default: idle($urandom_range(5, 15));
			endcase
		end

		// Wait out every outstanding result, then a little longer for strays
		drain();
		idle(SETTLE_CYCLES);

		$display("covered %0d differences (%0d saturated) and %0d backward shifts (%0d below day zero)",
			diff_n, sat_n, shift_n, uflow_n);
		$display("%0d directed and %0d random transactions, %0d mismatches",
			directed_rows.size(), RANDOM_ITEMS, mismatch_n);
		if (mismatch_n == 0)
			$display("tb_julian_day_date_arithmetic_core: done, clean");
		else
			$display("tb_julian_day_date_arithmetic_core: done, errors");
		$finish;
	end

endmodule

[julian_day_date_arithmetic_core.f]
design/jdd_pkg.sv
design/jdd_day_number.sv
design/jdd_from_day.sv
design/julian_day_date_arithmetic_core.sv
sim/tb_julian_day_date_arithmetic_core.sv
